FILE: rtl/core/sleb_pkg.sv
// Shared types and constants for the single-line edit buffer.
// No dependencies; imported by single_line_edit_buffer and its testbench.
package sleb_pkg;

  localparam int unsigned Capacity = 256;
  localparam int unsigned AddrW    = $clog2(Capacity);
  // length and cursor never exceed Capacity-1
  localparam int unsigned LenW     = $clog2(Capacity);
  // signed column sum: 8-bit unsigned column plus 16-bit signed delta
  localparam int unsigned SumW     = 18;

  typedef enum logic [2:0] {
    ACT_INSERT    = 3'd0,
    ACT_BACKSPACE = 3'd1,
    ACT_MOVE      = 3'd2,
    ACT_SET       = 3'd3,
    ACT_READ      = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_INS_FIN,
    S_BS_RD,
    S_BS_WR,
    S_BS_FIN,
    S_RD_WAIT
  } state_e;

  typedef struct packed {
    logic [2:0]         action;
    logic [7:0]         char_code;
    logic signed [15:0] delta;
    logic signed [15:0] position;
  } item_t;

  typedef struct packed {
    logic       count_done;
    logic [7:0] cursor_now;
    logic [7:0] length_now;
    logic [7:0] char_read;
  } result_t;

endpackage

FILE: rtl/core/single_line_edit_buffer.sv
// Single-line edit buffer: text memory, cursor/length registers and the shift sequencer.
// Depends on sleb_pkg.
//
//   channel   handshake             payload
//   command   start / busy          item_i   (sleb_pkg::item_t)
//   result    done_o, one cycle     result_o (sleb_pkg::result_t)
//
// Move, set, unknown, rejected insert/backspace, out-of-range read: result in the cycle
// after the accept. Read in range: registered memory read, then S_RD_WAIT. Insert and
// backspace: read/write states per tail entry, then a finish state; each tail entry costs one
// read and one write of the single-port text memory. busy is high while a word is in work.
// Reset clears state, cursor, length and done only; the text memory is never cleared.
// The receiver cannot stall: each result word is shown for exactly one cycle.
module single_line_edit_buffer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  sleb_pkg::item_t   item_i,
  output logic              done_o,
  output sleb_pkg::result_t result_o
);
  import sleb_pkg::*;

  state_e            state_q, state_d;
  item_t             item_q;
  logic [LenW-1:0]   cursor_q, cursor_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic              done_q;
  result_t           res_q, res_d;
  logic              emit;

  logic [7:0]        mem [Capacity];
  logic              mem_re, mem_we;
  logic [AddrW-1:0]  mem_ra, mem_wa;
  logic [7:0]        mem_wd, rdata_q;

  logic              accept;
  logic              ins_ok, bs_ok, rd_ok;
  logic signed [SumW-1:0] move_sum, set_sum, col_sum;
  logic [LenW-1:0]   col_clamped;
  logic [AddrW-1:0]  idx_dec, idx_inc;

  assign accept  = start && !busy;
  assign busy    = (state_q != S_IDLE);
  assign idx_dec = idx_q - AddrW'(1);
  assign idx_inc = idx_q + AddrW'(1);

  assign ins_ok = (item_i.char_code != 8'd0) && (len_q < LenW'(Capacity - 1));
  assign bs_ok  = (cursor_q != '0);
  assign rd_ok  = !item_i.position[15] &&
                  (SumW'(item_i.position) < $signed({{(SumW - LenW){1'b0}}, len_q}));

  assign move_sum = $signed({{(SumW - LenW){1'b0}}, cursor_q}) + SumW'(item_i.delta);
  assign set_sum  = SumW'(item_i.position);
  assign col_sum  = (item_i.action == ACT_MOVE) ? move_sum : set_sum;

  always_comb begin
    if (col_sum[SumW-1]) begin
      col_clamped = '0;
    end else if (col_sum > $signed({{(SumW - LenW){1'b0}}, len_q})) begin
      col_clamped = len_q;
    end else begin
      col_clamped = col_sum[LenW-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (item_i.action)
            ACT_INSERT:    if (ins_ok) state_d = (len_q > cursor_q) ? S_INS_RD : S_INS_FIN;
            ACT_BACKSPACE: if (bs_ok) state_d = (cursor_q < len_q) ? S_BS_RD : S_BS_FIN;
            ACT_READ:      if (rd_ok) state_d = S_RD_WAIT;
            default:       state_d = S_IDLE;
          endcase
        end
      end
      S_INS_RD:  state_d = S_INS_WR;
      S_INS_WR:  state_d = (LenW'(idx_dec) > cursor_q) ? S_INS_RD : S_INS_FIN;
      S_BS_RD:   state_d = S_BS_WR;
      S_BS_WR:   state_d = (LenW'(idx_inc) < len_q) ? S_BS_RD : S_BS_FIN;
      S_INS_FIN, S_BS_FIN, S_RD_WAIT: state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cursor_d = cursor_q;
    len_d    = len_q;
    idx_d    = idx_q;
    mem_re   = 1'b0;
    mem_ra   = idx_q;
    mem_we   = 1'b0;
    mem_wa   = idx_q;
    mem_wd   = rdata_q;
    emit     = 1'b0;
    res_d    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (item_i.action)
            ACT_INSERT: begin
              idx_d = AddrW'(len_q);
              emit  = !ins_ok;
            end
            ACT_BACKSPACE: begin
              idx_d = AddrW'(cursor_q);
              emit  = !bs_ok;
            end
            ACT_MOVE, ACT_SET: begin
              cursor_d = col_clamped;
              emit     = 1'b1;
            end
            ACT_READ: begin
              mem_re = rd_ok;
              mem_ra = item_i.position[AddrW-1:0];
              emit   = !rd_ok;
            end
            default: emit = 1'b1;
          endcase
        end
      end
      S_INS_RD: begin
        mem_re = 1'b1;
        mem_ra = idx_dec;
      end
      S_INS_WR: begin
        mem_we = 1'b1;
        idx_d  = idx_dec;
      end
      S_INS_FIN: begin
        mem_we   = 1'b1;
        mem_wa   = AddrW'(cursor_q);
        mem_wd   = item_q.char_code;
        cursor_d = cursor_q + LenW'(1);
        len_d    = len_q + LenW'(1);
        emit     = 1'b1;
        res_d.count_done = 1'b1;
      end
      S_BS_RD: begin
        mem_re = 1'b1;
      end
      S_BS_WR: begin
        mem_we = 1'b1;
        mem_wa = idx_dec;
        idx_d  = idx_inc;
      end
      S_BS_FIN: begin
        cursor_d = cursor_q - LenW'(1);
        len_d    = len_q - LenW'(1);
        emit     = 1'b1;
        res_d.count_done = 1'b1;
      end
      S_RD_WAIT: begin
        emit            = 1'b1;
        res_d.char_read = rdata_q;
      end
      default: emit = 1'b0;
    endcase
    res_d.cursor_now = 8'(cursor_d);
    res_d.length_now = 8'(len_d);
  end

  // text memory, one read or one write per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_q <= mem[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cursor_q <= '0;
      len_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      len_q    <= len_d;
      done_q   <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (accept) item_q <= item_i;
    if (emit) res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

`ifndef NO_ASSERTIONS
  a_cursor_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= len_q) else $error("cursor past end of line");

  a_len_below_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(Capacity - 1)) else $error("line length over capacity");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || done_o)) else $error("accepted word neither in work nor done");

  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy || $past(accept)) else $error("result while shift still running");
`endif

endmodule

FILE: sim/single_line_edit_buffer_tb.sv
// Self-checking testbench for single_line_edit_buffer: directed and random edit words.
// Expected status words come from a line model kept inside the bench.
// Depends on sleb_pkg and the single_line_edit_buffer RTL.
module single_line_edit_buffer_tb;
  import sleb_pkg::*;

  localparam int CycleLimit  = 1_200_000;
  localparam int DrainCycles = 520;   // longest shift: a tail of 254 entries
  localparam logic [2:0] ActRsvdLo = 3'd5;
  localparam logic [2:0] ActRsvdHi = 3'd7;

  typedef struct {
    item_t word;
    int    gap;     // idle cycles before the word is offered
    bit    drain;   // hold the word until every status has come back
  } keystroke_t;

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start  = 1'b0;
  item_t   item_i = '0;
  logic    busy;
  logic    done_o;
  result_t result_o;

  keystroke_t keystroke_q[$];
  result_t    pending_status_q[$];
  int         keys_accepted = 0;
  int         statuses_seen = 0;
  int         mismatches    = 0;
  int         cycle_cnt     = 0;
  bit         gaps_on       = 1'b1;

  // line model
  logic [7:0] text_mem [Capacity];
  int         cur_col  = 0;
  int         line_len = 0;

  single_line_edit_buffer u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int clamp_col(int col);
    if (col < 0) return 0;
    if (col > line_len) return line_len;
    return col;
  endfunction

  function automatic result_t apply_edit(item_t w);
    result_t st;
    int      pos;
    st  = '0;
    pos = int'(w.position);
    case (w.action)
      ACT_INSERT: begin
        if (w.char_code != 8'd0 && line_len < int'(Capacity) - 1) begin
          for (int i = line_len; i > cur_col; i--) text_mem[i] = text_mem[i-1];
          text_mem[cur_col] = w.char_code;
          cur_col++;
          line_len++;
          st.count_done = 1'b1;
        end
      end
      ACT_BACKSPACE: begin
        if (cur_col > 0) begin
          for (int i = cur_col; i < line_len; i++) text_mem[i-1] = text_mem[i];
          cur_col--;
          line_len--;
          st.count_done = 1'b1;
        end
      end
      ACT_MOVE: cur_col = clamp_col(cur_col + int'(w.delta));
      ACT_SET:  cur_col = clamp_col(pos);
      ACT_READ: begin
        if (pos >= 0 && pos < line_len) st.char_read = text_mem[pos];
      end
      default: ;
    endcase
    st.cursor_now = cur_col[7:0];
    st.length_now = line_len[7:0];
    return st;
  endfunction

  task automatic queue_key(input logic [2:0] act, input logic [7:0] ch,
                           input logic [15:0] dl, input logic [15:0] ps, input bit drain);
    keystroke_t k;
    int         r;
    r = $urandom_range(0, 99);
    k.word.action    = act;
    k.word.char_code = ch;
    k.word.delta     = dl;
    k.word.position  = ps;
    k.drain          = drain;
    if (!gaps_on || r < 50) k.gap = 0;
    else if (r < 90)        k.gap = $urandom_range(1, 3);
    else                    k.gap = $urandom_range(10, 40);
    keystroke_q.push_back(k);
  endtask

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // driver: at most one nonblocking write to start per edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        pending_status_q.push_back(apply_edit(item_i));
        keys_accepted++;
      end
      if (start && busy) begin
        // word still offered, keep it
      end else if (keystroke_q.size() == 0) begin
        start <= 1'b0;
      end else if (keystroke_q[0].drain && keys_accepted != statuses_seen) begin
        start <= 1'b0;
      end else if (keystroke_q[0].gap != 0) begin
        keystroke_q[0].gap--;
        start <= 1'b0;
      end else begin
        item_i <= keystroke_q[0].word;
        keystroke_q.pop_front();
        start <= 1'b1;
      end
    end
  end

  // monitor: every done_o cycle carries one status word
  always @(posedge clk_i) begin
    result_t exp_st;
    if (rst_ni && done_o) begin
      if (pending_status_q.size() == 0) begin
        $error("status word with none expected: %h", result_o);
        mismatches++;
      end else begin
        exp_st = pending_status_q.pop_front();
        check_field("count_done", int'(exp_st.count_done), int'(result_o.count_done));
        check_field("cursor_now", int'(exp_st.cursor_now), int'(result_o.cursor_now));
        check_field("length_now", int'(exp_st.length_now), int'(result_o.length_now));
        check_field("char_read",  int'(exp_st.char_read),  int'(result_o.char_read));
      end
      statuses_seen <= statuses_seen + 1;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int         ins_pct [6];
    int         bs_pct  [6];
    int         r;
    int         sel;
    logic [2:0] act;
    logic [7:0] ch;
    logic [15:0] dl;
    logic [15:0] ps;

    ins_pct = '{80, 80, 80, 60, 30, 15};
    bs_pct  = '{5, 5, 5, 10, 40, 50};

    // directed: empty line, extremes of every field, each corner of the editor
    queue_key(ACT_READ,      8'h00, 16'sd0,  16'sd0,  1'b0);
    queue_key(ACT_BACKSPACE, 8'h00, 16'sd0,  16'sd0,  1'b0);
    queue_key(ACT_INSERT,    8'h00, 16'hFFFF, 16'hFFFF, 1'b0);  // zero char: no-op
    queue_key(ACT_INSERT,    8'hFF, 16'h0000, 16'h0000, 1'b0);
    queue_key(ACT_INSERT,    8'h01, 16'sd0,  16'sd0,  1'b0);
    queue_key(ACT_INSERT,    8'h80, 16'sd0,  16'sd0,  1'b0);
    queue_key(ACT_SET,       8'h00, 16'sd0,  16'h8000, 1'b0);
    queue_key(ACT_INSERT,    8'h7F, 16'sd0,  16'sd0,  1'b0);    // at column 0, full shift
    queue_key(ACT_MOVE,      8'h00, 16'h7FFF, 16'sd0, 1'b0);
    queue_key(ACT_MOVE,      8'h00, 16'h8000, 16'sd0, 1'b0);
    queue_key(ACT_SET,       8'h00, 16'sd0,  16'h7FFF, 1'b0);
    queue_key(ACT_READ,      8'h00, 16'sd0,  16'hFFFF, 1'b0);
    queue_key(ACT_READ,      8'h00, 16'sd0,  16'sd0,  1'b0);
    queue_key(ACT_READ,      8'h00, 16'sd0,  16'sd3,  1'b0);
    queue_key(ACT_READ,      8'h00, 16'sd0,  16'sd4,  1'b0);
    queue_key(ACT_READ,      8'h00, 16'sd0,  16'h7FFF, 1'b0);
    queue_key(ACT_BACKSPACE, 8'h00, 16'sd0,  16'sd0,  1'b0);
    queue_key(ACT_SET,       8'h00, 16'sd0,  16'sd1,  1'b0);
    queue_key(ACT_BACKSPACE, 8'h00, 16'sd0,  16'sd0,  1'b0);    // mid-line, tail shift
    queue_key(ActRsvdLo,     8'hFF, 16'hFFFF, 16'hFFFF, 1'b0);
    queue_key(ActRsvdLo + 3'd1, 8'h55, 16'h5555, 16'hAAAA, 1'b0);
    queue_key(ActRsvdHi,     8'hAA, 16'hAAAA, 16'h5555, 1'b0);
    queue_key(ACT_MOVE,      8'h00, 16'sd1,  16'sd0,  1'b0);
    queue_key(ACT_MOVE,      8'h00, 16'hFFFF, 16'sd0, 1'b0);

    // random: fill toward full, hover there, then erase back down
    for (int seg = 0; seg < 6; seg++) begin
      gaps_on = (seg != 2);
      for (int n = 0; n < 100; n++) begin
        r   = $urandom_range(0, 99);
        ch  = 8'($urandom_range(0, 255));
        dl  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20) - 10);
        ps  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 270));
        if (r < ins_pct[seg]) begin
          act = ACT_INSERT;
          ch  = ($urandom_range(0, 49) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
        end else if (r < ins_pct[seg] + bs_pct[seg]) begin
          act = ACT_BACKSPACE;
        end else begin
          sel = $urandom_range(0, 19);
          if (sel < 9)       act = ACT_READ;
          else if (sel < 14) act = ACT_MOVE;
          else if (sel < 18) act = ACT_SET;
          else               act = 3'($urandom_range(ActRsvdHi, ActRsvdLo));
        end
        queue_key(act, ch, dl, ps, (n == 0) && (seg == 3 || seg == 5));
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (keystroke_q.size() != 0 || start || keys_accepted != statuses_seen);
    repeat (DrainCycles) @(posedge clk_i);

    if (pending_status_q.size() != 0) begin
      $error("%0d status words never arrived", pending_status_q.size());
      mismatches++;
    end
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/sleb_pkg.sv
rtl/core/single_line_edit_buffer.sv
sim/single_line_edit_buffer_tb.sv
